/* design/evhp_pkg.sv */
// Shared types and constants for the Ethernet 802.1Q header parser.
`timescale 1ns / 1ps
package evhp_pkg;

  // Largest frame length counted before the count saturates
  localparam int MAX_FRAME_BYTES = 16383;
  localparam int COUNT_W         = $clog2(MAX_FRAME_BYTES + 1);
  localparam int MAC_W           = 48;
  localparam int TYPE_W          = 16;
  localparam int PAYLOAD_W       = 14;
  localparam int CMP_W           = (COUNT_W > PAYLOAD_W) ? COUNT_W : PAYLOAD_W;
  localparam logic [PAYLOAD_W-1:0] PAYLOAD_MAX = '1;

  // Byte offsets of the header fields
  localparam logic [COUNT_W-1:0] DEST_END  = COUNT_W'(6);
  localparam logic [COUNT_W-1:0] SRC_END   = COUNT_W'(12);
  localparam logic [COUNT_W-1:0] TYPE_END  = COUNT_W'(14);
  localparam logic [COUNT_W-1:0] TCI_END   = COUNT_W'(16);
  localparam logic [COUNT_W-1:0] INNER_END = COUNT_W'(18);
  localparam logic [CMP_W-1:0]   HDR_PLAIN  = CMP_W'(14);
  localparam logic [CMP_W-1:0]   HDR_TAGGED = CMP_W'(18);

  // Result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SHORT = 2'd1;
  localparam logic [1:0] STATUS_LONG  = 2'd2;

  // Register map
  localparam int          PADDR_W      = 3;
  localparam logic [0:0]  REG_VLAN_TAG = 1'b0;
  localparam logic [15:0] VLAN_TAG_RESET = 16'h8100;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [15:0] ether_type;
    logic        tagged_res;
    logic [2:0]  tag_pri;
    logic        canon_fmt;
    logic [11:0] vlan_ident;
    logic [13:0] payload_length;
    logic [1:0]  status;
  } out_item_t;

  // Everything captured from one frame, handed from capture to result stage
  typedef struct packed {
    logic [MAC_W-1:0]   dest;
    logic [MAC_W-1:0]   source;
    logic [TYPE_W-1:0]  outer_type;
    logic [TYPE_W-1:0]  tag_control;
    logic [TYPE_W-1:0]  inner_type;
    logic [COUNT_W-1:0] length;
    logic               overflowed;
  } frame_t;

endpackage

/* design/evhp_capture.sv */
// Byte-wise header capture and per-frame record register.
`timescale 1ns / 1ps
module evhp_capture (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  evhp_pkg::in_item_t in_data,
  input  logic               frame_take,
  output logic               frame_valid,
  output evhp_pkg::frame_t   frame
);
  import evhp_pkg::*;

  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [MAC_W-1:0]   dest_shift, dest_shift_next;
  logic [MAC_W-1:0]   source_shift, source_shift_next;
  logic [TYPE_W-1:0]  outer_type, outer_type_next;
  logic [TYPE_W-1:0]  tag_control, tag_control_next;
  logic [TYPE_W-1:0]  inner_type, inner_type_next;
  logic               overflowed, overflowed_next;
  logic               accept;
  logic [7:0]         b;

  assign in_stall = frame_valid && !frame_take;
  assign accept   = in_valid && !in_stall;
  assign b        = in_data.data_byte;

  always_comb begin
    dest_shift_next   = dest_shift;
    source_shift_next = source_shift;
    outer_type_next   = outer_type;
    tag_control_next  = tag_control;
    inner_type_next   = inner_type;
    if (byte_count < DEST_END) begin
      dest_shift_next = {dest_shift[MAC_W-9:0], b};
    end else if (byte_count < SRC_END) begin
      source_shift_next = {source_shift[MAC_W-9:0], b};
    end else if (byte_count < TYPE_END) begin
      outer_type_next = {outer_type[TYPE_W-9:0], b};
    end else if (byte_count < TCI_END) begin
      tag_control_next = {tag_control[TYPE_W-9:0], b};
    end else if (byte_count < INNER_END) begin
      inner_type_next = {inner_type[TYPE_W-9:0], b};
    end
    // Saturate the count and remember that the frame ran over
    if (byte_count >= COUNT_W'(MAX_FRAME_BYTES)) begin
      byte_count_next = byte_count;
      overflowed_next = 1'b1;
    end else begin
      byte_count_next = byte_count + COUNT_W'(1);
      overflowed_next = overflowed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      dest_shift   <= '0;
      source_shift <= '0;
      outer_type   <= '0;
      tag_control  <= '0;
      inner_type   <= '0;
      overflowed   <= 1'b0;
    end else if (accept) begin
      if (in_data.last_byte) begin
        // Clear the frame state for the next frame
        byte_count   <= '0;
        dest_shift   <= '0;
        source_shift <= '0;
        outer_type   <= '0;
        tag_control  <= '0;
        inner_type   <= '0;
        overflowed   <= 1'b0;
      end else begin
        byte_count   <= byte_count_next;
        dest_shift   <= dest_shift_next;
        source_shift <= source_shift_next;
        outer_type   <= outer_type_next;
        tag_control  <= tag_control_next;
        inner_type   <= inner_type_next;
        overflowed   <= overflowed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (accept && in_data.last_byte) begin
      frame_valid <= 1'b1;
    end else if (frame_take) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.last_byte) begin
      frame.dest        <= dest_shift_next;
      frame.source      <= source_shift_next;
      frame.outer_type  <= outer_type_next;
      frame.tag_control <= tag_control_next;
      frame.inner_type  <= inner_type_next;
      frame.length      <= byte_count_next;
      frame.overflowed  <= overflowed_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= COUNT_W'(MAX_FRAME_BYTES))
    else $error("byte count above frame maximum");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.last_byte |=> byte_count == '0 && !overflowed)
    else $error("frame state not cleared after last byte");

  a_no_frame_overrun: assert property (@(posedge clk) disable iff (rst)
    frame_valid && !frame_take |=> frame_valid && $stable(frame))
    else $error("pending frame record lost or changed");

endmodule

/* design/evhp_result.sv */
// Header record build from a captured frame, with the output register.
`timescale 1ns / 1ps
module evhp_result (
  input  logic                clk,
  input  logic                rst,
  input  logic                frame_valid,
  input  evhp_pkg::frame_t    frame,
  output logic                frame_take,
  input  logic [15:0]         vlan_tag_type,
  output logic                out_valid,
  input  logic                out_stall,
  output evhp_pkg::out_item_t out_data
);
  import evhp_pkg::*;

  logic             out_load;
  logic             is_vlan;
  logic [CMP_W-1:0] len;
  logic [CMP_W-1:0] hdr;
  logic [CMP_W-1:0] pay;
  logic             short_frame;
  logic [15:0]      tci;
  out_item_t        rec;

  assign out_load   = !out_valid || !out_stall;
  assign frame_take = frame_valid && out_load;

  always_comb begin
    is_vlan     = frame.outer_type == vlan_tag_type;
    len         = CMP_W'(frame.length);
    hdr         = is_vlan ? HDR_TAGGED : HDR_PLAIN;
    short_frame = (len <= HDR_PLAIN) || (len < hdr);
    pay         = len - hdr;
    tci         = is_vlan ? frame.tag_control : 16'd0;
    rec         = '0;
    if (short_frame) begin
      rec.status = STATUS_SHORT;
    end else begin
      rec.dest_mac      = frame.dest;
      rec.source_mac    = frame.source;
      rec.ether_type    = is_vlan ? frame.inner_type : frame.outer_type;
      rec.tagged_res    = is_vlan;
      rec.tag_pri       = tci[15:13];
      rec.canon_fmt     = tci[12];
      rec.vlan_ident    = tci[11:0];
      if (frame.overflowed || pay > CMP_W'(PAYLOAD_MAX)) begin
        rec.payload_length = PAYLOAD_MAX;
      end else begin
        rec.payload_length = PAYLOAD_W'(pay);
      end
      rec.status = frame.overflowed ? STATUS_LONG : STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_take) begin
      out_data <= rec;
    end
  end

  a_short_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == STATUS_SHORT |->
      out_data.dest_mac == '0 && out_data.payload_length == '0 && !out_data.tagged_res)
    else $error("short frame record carries data");

  a_untagged_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.tagged_res |->
      out_data.vlan_ident == '0 && out_data.tag_pri == '0 && !out_data.canon_fmt)
    else $error("untagged record has tag fields");

  a_long_saturates: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == STATUS_LONG |-> out_data.payload_length == PAYLOAD_MAX)
    else $error("long frame payload length not saturated");

endmodule

/* design/ethernet_vlan_header_parser.sv */
// Top level of the Ethernet 802.1Q header parser with its register port.
// A last byte accepted loads the capture frame record; its header record then goes to the out_data register.
// Throughput: one byte per cycle; the capture stage and the output register each
// hold one frame record, so a stalled output stalls input only once both are full.
// Reset (rst, synchronous): clears frame state and valid flags, and sets
// vlan_tag_type to 0x8100. No clearing pass; bytes are taken the cycle after reset.
`timescale 1ns / 1ps
module ethernet_vlan_header_parser (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  evhp_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output evhp_pkg::out_item_t              out_data,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [evhp_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import evhp_pkg::*;

  logic [15:0] vlan_tag_type;
  logic        frame_valid;
  logic        frame_take;
  frame_t      frame;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vlan_tag_type <= VLAN_TAG_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_VLAN_TAG) begin
      vlan_tag_type <= pwdata[15:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_VLAN_TAG) begin
      prdata = {16'd0, vlan_tag_type};
    end else begin
      prdata = '0;
    end
  end

  evhp_capture u_capture (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .frame_take  (frame_take),
    .frame_valid (frame_valid),
    .frame       (frame)
  );

  evhp_result u_result (
    .clk           (clk),
    .rst           (rst),
    .frame_valid   (frame_valid),
    .frame         (frame),
    .frame_take    (frame_take),
    .vlan_tag_type (vlan_tag_type),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

endmodule
